// ===== hw/rtl/dpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dpcm_pkg
// Shared types and constants for the DPCM pixel codec.
// ----------------------------------------------------------------------------
package dpcm_pkg;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0] PRED_RESET = 8'd128;
    localparam logic [PIX_W-1:0] CODE_BIAS  = 8'd127;
    localparam logic [DIM_W-1:0] DIM_RESET  = 13'd512;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECODE_MODE  = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    // raster position of the pixel now being coded
    typedef struct packed {
        logic row_start;
        logic row_end;
        logic frame_end;
    } raster_pos_t;

endpackage

// ===== hw/rtl/dpcm_pixel_codec.sv =====
// ----------------------------------------------------------------------------
// dpcm_pixel_codec
// DPCM coder for 8-bit raster pixels with row and frame predictor restarts.
// ----------------------------------------------------------------------------
//   channel   ports                          direction
//   s_        s_valid/s_ready, s_value_in    pixel or code in
//   m_        m_valid/m_ready, m_code_out,   code, rebuilt pixel, flags out
//             m_pixel_out, m_row_end,
//             m_frame_end
//   cfg_      cfg_valid/cfg_ready,           register writes, always ready
//             cfg_index, cfg_data
//
// One pixel per cycle sustained while m_ready stays high; a pixel passes
// from the input register through a single subtract, halve and add into the
// result register, and the predictor loop closes as each result is registered.
// Both stages advance together when the result register is empty or taken,
// so a stall on m_ready backs up into s_ready without losing a request.
// Synchronous reset returns predictor to 128 and counters to the frame start.
module dpcm_pixel_codec #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_value_in,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_code_out,
    output logic [7:0]                     m_pixel_out,
    output logic                           m_row_end,
    output logic                           m_frame_end,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpcm_pkg::DIM_W-1:0]     cfg_data
);
    import dpcm_pkg::*;

    logic              decode_mode_reg;
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;

    logic              in_valid_reg;
    pixel_t            in_value_reg;

    logic              out_valid_reg;
    pixel_t            code_reg;
    pixel_t            pixel_reg;
    logic              row_end_reg;
    logic              frame_end_reg;

    pixel_t            pred_reg, pred_next;
    pixel_t            row_first_reg, row_first_next;

    logic              advance;
    logic              fire;
    raster_pos_t       pos;

    logic signed [PIX_W:0] diff;
    logic signed [PIX_W:0] half;
    pixel_t                code;
    pixel_t                pixel;

    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    dpcm_raster_counter #(
        .MAX_DIM (MAX_DIM)
    ) u_counter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (fire),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pos          (pos)
    );

    always_comb begin
        diff = $signed({1'b0, in_value_reg}) - $signed({1'b0, pred_reg});
        // halve toward zero: bias negative values by one before the shift
        half = (diff + $signed({{PIX_W{1'b0}}, diff[PIX_W]})) >>> 1;
        if (decode_mode_reg) begin
            code = in_value_reg;
        end else begin
            code = half[PIX_W-1:0] + CODE_BIAS;
        end
        pixel = {code[PIX_W-2:0], 1'b0} + PIX_W'(2) + pred_reg;

        row_first_next = pos.row_start ? pixel : row_first_reg;
        if (pos.frame_end) begin
            pred_next = PRED_RESET;
        end else if (pos.row_end) begin
            pred_next = row_first_next;
        end else begin
            pred_next = pixel;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_mode_reg  <= 1'b0;
            frame_width_reg  <= DIM_RESET;
            frame_height_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DECODE_MODE:  decode_mode_reg  <= cfg_data[0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_value_reg <= s_value_in;
        end
    end

    // predictor state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pred_reg      <= PRED_RESET;
            row_first_reg <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                pred_reg      <= pred_next;
                row_first_reg <= row_first_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            code_reg      <= code;
            pixel_reg     <= pixel;
            row_end_reg   <= pos.row_end;
            frame_end_reg <= pos.frame_end;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_code_out  = code_reg;
    assign m_pixel_out = pixel_reg;
    assign m_row_end   = row_end_reg;
    assign m_frame_end = frame_end_reg;

endmodule

// ===== hw/rtl/dpcm_raster_counter.sv =====
// ----------------------------------------------------------------------------
// dpcm_raster_counter
// Column and row counters that flag row start, row end and frame end.
// ----------------------------------------------------------------------------
module dpcm_raster_counter #(
    parameter int MAX_DIM = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [dpcm_pkg::DIM_W-1:0]  frame_width,
    input  logic [dpcm_pkg::DIM_W-1:0]  frame_height,
    output dpcm_pkg::raster_pos_t       pos
);
    import dpcm_pkg::*;

    localparam int CNT_W  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int LIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = ((LIM_W > DIM_W) ? LIM_W : DIM_W) + 1;
    localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(MAX_DIM);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] width_lim;
    logic [CMP_W-1:0] height_lim;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_inc;

    // zero counts as one, oversize saturates at the maximum
    function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (v == '0) begin
            return CMP_W'(1);
        end else if (ext > MAX_LIM) begin
            return MAX_LIM;
        end
        return ext;
    endfunction

    always_comb begin
        width_lim  = clamp_dim(frame_width);
        height_lim = clamp_dim(frame_height);
        col_inc    = CMP_W'(col_reg) + CMP_W'(1);
        row_inc    = CMP_W'(row_reg) + CMP_W'(1);

        pos.row_start = (col_reg == '0);
        pos.row_end   = (col_inc >= width_lim);
        pos.frame_end = pos.row_end && (row_inc >= height_lim);

        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (pos.frame_end) begin
                col_next = '0;
                row_next = '0;
            end else if (pos.row_end) begin
                col_next = '0;
                row_next = row_inc[CNT_W-1:0];
            end else begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dpcm_pixel_codec: a queued pixel driver, a result
// monitor and a per-pixel model of the codec's codes and row and frame behavior.
// ----------------------------------------------------------------------------
module tb;
    import dpcm_pkg::*;

    localparam int MAX_DIM    = 4096;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        pixel_t code;
        pixel_t pixel;
        logic   row_end;
        logic   frame_end;
    } coded_pixel_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_value_in = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [7:0]       m_code_out;
    logic [7:0]       m_pixel_out;
    logic             m_row_end;
    logic             m_frame_end;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;

    // predictor copy of the codec registers and state
    logic             decode_on = 1'b0;
    logic [DIM_W-1:0] row_width = DIM_RESET;
    logic [DIM_W-1:0] rows_per_frame = DIM_RESET;
    pixel_t           last_pixel = PRED_RESET;
    pixel_t           row_head = '0;
    int               column_pos = 0;
    int               row_pos = 0;

    pixel_t           pixels_to_send[$];
    coded_pixel_t     codes_due[$];
    logic             steady = 1'b0;
    int               mismatch_count = 0;
    int               idle_cycles = 0;

    dpcm_pixel_codec #(.MAX_DIM(MAX_DIM)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value_in  (s_value_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_out  (m_code_out),
        .m_pixel_out (m_pixel_out),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_dim(logic [DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    // codes one pixel and advances the predictor and raster counters
    function automatic coded_pixel_t code_pixel(pixel_t v);
        coded_pixel_t r;
        int diff;
        diff = int'(v) - int'(last_pixel);
        if (decode_on) begin
            r.code = v;
        end else begin
            r.code = 8'(diff / 2 + int'(CODE_BIAS));
        end
        r.pixel = 8'(2 * int'(r.code) - 2 * int'(CODE_BIAS) + int'(last_pixel));
        if (column_pos == 0) row_head = r.pixel;
        r.row_end   = (column_pos + 1 >= clamp_dim(row_width));
        r.frame_end = r.row_end && (row_pos + 1 >= clamp_dim(rows_per_frame));
        if (r.frame_end) begin
            last_pixel = PRED_RESET;
            column_pos = 0;
            row_pos    = 0;
        end else if (r.row_end) begin
            last_pixel = row_head;
            column_pos = 0;
            row_pos    = row_pos + 1;
        end else begin
            last_pixel = r.pixel;
            column_pos = column_pos + 1;
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return '0;
            1: return DIM_W'(MAX_DIM);
            2: return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
            3: return DIM_W'($urandom_range(9, 600));
            default: return DIM_W'($urandom_range(1, 8));
        endcase
    endfunction

    // pixel driver
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            codes_due.push_back(code_pixel(s_value_in));
        end
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pixels_to_send.size() > 0 && (steady || $urandom_range(0, 99) >= 20)) begin
                s_valid    <= 1'b1;
                s_value_in <= pixels_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        coded_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (codes_due.size() == 0) begin
                $error("result with none pending: code_out %0d pixel_out %0d",
                       m_code_out, m_pixel_out);
                mismatch_count++;
            end else begin
                want = codes_due.pop_front();
                if (m_code_out !== want.code) begin
                    $error("code_out expected %0d actual %0d", want.code, m_code_out);
                    mismatch_count++;
                end
                if (m_pixel_out !== want.pixel) begin
                    $error("pixel_out expected %0d actual %0d", want.pixel, m_pixel_out);
                    mismatch_count++;
                end
                if (m_row_end !== want.row_end) begin
                    $error("row_end expected %0b actual %0b", want.row_end, m_row_end);
                    mismatch_count++;
                end
                if (m_frame_end !== want.frame_end) begin
                    $error("frame_end expected %0b actual %0b", want.frame_end, m_frame_end);
                    mismatch_count++;
                end
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // register shadow follows accepted writes
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DECODE_MODE:  decode_on <= cfg_data[0];
                CFG_FRAME_WIDTH:  row_width <= cfg_data;
                CFG_FRAME_HEIGHT: rows_per_frame <= cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // test sequence waits until every queued pixel is sent and every result is back
    task automatic wait_idle();
        do @(negedge aclk);
        while (pixels_to_send.size() != 0 || s_valid || codes_due.size() != 0);
    endtask

    initial begin
        int sent;
        int phase;
        int burst;
        pixel_t v;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // value extremes over a 3x2 frame, encode
        cfg_write(CFG_DECODE_MODE, '0);
        cfg_write(CFG_FRAME_WIDTH, 13'd3);
        cfg_write(CFG_FRAME_HEIGHT, 13'd2);
        @(negedge aclk);
        pixels_to_send.push_back(8'd0);
        pixels_to_send.push_back(8'd255);
        pixels_to_send.push_back(8'd128);
        pixels_to_send.push_back(8'd1);
        pixels_to_send.push_back(8'd254);
        pixels_to_send.push_back(8'd127);
        wait_idle();

        // zero dimensions act as one, decode with wrapping codes
        cfg_write(CFG_DECODE_MODE, 13'h1fff);
        cfg_write(CFG_FRAME_WIDTH, '0);
        cfg_write(CFG_FRAME_HEIGHT, '0);
        @(negedge aclk);
        pixels_to_send.push_back(8'd0);
        pixels_to_send.push_back(8'd255);
        pixels_to_send.push_back(8'd127);
        pixels_to_send.push_back(8'd128);
        wait_idle();

        // oversized dimensions clamp, then a shrink ends row and frame at once
        cfg_write(CFG_DECODE_MODE, 13'd2);
        cfg_write(CFG_FRAME_WIDTH, 13'h1fff);
        cfg_write(CFG_FRAME_HEIGHT, 13'd4097);
        @(negedge aclk);
        pixels_to_send.push_back(8'd255);
        pixels_to_send.push_back(8'd0);
        pixels_to_send.push_back(8'd200);
        pixels_to_send.push_back(8'd50);
        wait_idle();
        cfg_write(CFG_FRAME_WIDTH, 13'd2);
        cfg_write(CFG_FRAME_HEIGHT, 13'd1);
        @(negedge aclk);
        pixels_to_send.push_back(8'd10);
        pixels_to_send.push_back(8'd20);
        pixels_to_send.push_back(8'd30);
        wait_idle();

        // mode flips partway through a frame
        cfg_write(CFG_FRAME_WIDTH, 13'd5);
        cfg_write(CFG_FRAME_HEIGHT, 13'd3);
        cfg_write(CFG_DECODE_MODE, 13'd1);
        @(negedge aclk);
        pixels_to_send.push_back(8'd127);
        pixels_to_send.push_back(8'd0);
        pixels_to_send.push_back(8'd255);
        wait_idle();
        cfg_write(CFG_DECODE_MODE, 13'd4);
        cfg_write(CFG_SPARE, 13'h0aaa);
        @(negedge aclk);
        pixels_to_send.push_back(8'd90);
        pixels_to_send.push_back(8'd170);
        pixels_to_send.push_back(8'd30);
        wait_idle();

        sent  = 0;
        phase = 0;
        while (sent < 1650) begin
            if ($urandom_range(0, 1) == 1) cfg_write(CFG_DECODE_MODE, DIM_W'($urandom_range(0, 8191)));
            if ($urandom_range(0, 2) != 0) cfg_write(CFG_FRAME_WIDTH, pick_dim());
            if ($urandom_range(0, 2) != 0) cfg_write(CFG_FRAME_HEIGHT, pick_dim());
            if ($urandom_range(0, 15) == 0) cfg_write(CFG_SPARE, DIM_W'($urandom_range(0, 8191)));
            burst = (phase == 6) ? 300 : $urandom_range(20, 120);
            @(negedge aclk);
            steady = (phase == 6);
            repeat (burst) begin
                case ($urandom_range(0, 9))
                    0: v = 8'd0;
                    1: v = 8'd255;
                    default: v = 8'($urandom_range(0, 255));
                endcase
                pixels_to_send.push_back(v);
            end
            sent += burst;
            wait_idle();
            steady = 1'b0;
            phase++;
        end

        repeat (6) @(posedge aclk);
        if (mismatch_count == 0 && codes_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
